@@ rtl/sist_pkg.sv @@
package sist_pkg;

    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int OUT_W   = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OUT_DONE   = 2'd0,
        OUT_DUP    = 2'd1,
        OUT_FULL   = 2'd2,
        OUT_ABSENT = 2'd3
    } outcome_t;

    // Packed MSB first: found lands in bit 0.
    typedef struct packed {
        logic               is_full;
        logic [COUNT_W-1:0] element_count;
        outcome_t           outcome;
        logic [SLOT_W-1:0]  slot;
        logic               found;
    } result_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic sample;   // latch match line on input beat
        logic add_en;   // write at slot == count
        logic rem_en;   // overwrite matching slot with tail entry
    } cell_ctl_t;

endpackage

@@ rtl/sist_cell.sv @@
module sist_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sist_pkg::cell_ctl_t         ctl,
    input  logic [CW-1:0]               count,
    input  logic [sist_pkg::VAL_W-1:0]  value_in,
    input  logic [sist_pkg::VAL_W-1:0]  wr_value,
    input  logic [sist_pkg::VAL_W-1:0]  tail_in,
    output logic                        hit,
    output logic [sist_pkg::VAL_W-1:0]  tail_out
);
    import sist_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    logic             hit_reg;
    logic             hit_next;
    logic             in_range;
    logic             is_last;
    logic             at_end;

    assign in_range = CW'(IDX) < count;
    assign at_end   = CW'(IDX) == count;
    assign is_last  = (count != '0) && (CW'(IDX) == (count - CW'(1)));
    assign tail_out = is_last ? entry_reg : '0;
    assign hit      = hit_reg;

    // match line, only live below count
    assign hit_next = ctl.sample ? (in_range && (entry_reg == value_in)) : hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_en && at_end)
        begin
            entry_reg <= wr_value;
        end
        else if (ctl.rem_en && hit_reg)
        begin
            entry_reg <= tail_in;
        end
    end

endmodule

@@ rtl/small_integer_set_table.sv @@
// small_integer_set_table: set of distinct 32-bit signed integers.
// Input beat: s_tuser = command (0 query, 1 add, 2 remove, 3 clear),
// s_tdata = value. Each input beat yields exactly one output beat on m_*.
// Output m_tdata fields from bit 0 up: found, slot[6], outcome[2],
// element_count[7], is_full, then zero fill to 24 bits.
// cfg_we/cfg_wdata write capacity_limit (saturated to SET_DEPTH); write
// only while idle.
// Operation: at the accept edge every cell compares its entry against
// the value and latches its match line, and the last valid entry is
// captured for a possible remove. In ST_EXEC the block encodes the hit
// slot, updates count, writes at most one cell and loads the output
// register. The result is valid on the cycle after that; a new beat is
// taken once the block is back in ST_IDLE and the output register is
// empty or being drained, so a beat is never taken while one executes.
// A stalled m_tready holds the result and s_tready stays low until it is
// taken. Reset empties the set (count 0), clears the output register and
// sets the capacity limit to 64; entry storage is not cleared.
module small_integer_set_table #(
    parameter int SET_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,     // capacity_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // value
    input  logic [1:0]  s_tuser,       // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // found, slot, outcome, element_count, is_full
);
    import sist_pkg::*;

    localparam int CW = $clog2(SET_DEPTH + 1);      // count width
    localparam int IW = $clog2(SET_DEPTH);          // slot index width
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;  // limit compare width

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg, count_next;
    cmd_t             cmd_reg;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] tail_reg, tail_next;
    result_t          res_reg, res_next;
    logic             m_valid_reg, m_valid_next;

    cell_ctl_t        ctl;
    logic             accept;
    logic [SET_DEPTH-1:0] hit_vec;
    logic [VAL_W-1:0] tail_vec [SET_DEPTH];
    logic             found_any;
    logic [IW-1:0]    slot_enc;
    logic [LW-1:0]    eff_limit;
    logic             at_limit;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_W - $bits(result_t))'(0), res_reg};

    // ---- cell row: one entry per cell, compare on the broadcast value ----
    genvar gi;
    generate
        for (gi = 0; gi < SET_DEPTH; gi++)
        begin : g_cell
            sist_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .count    (count_reg),
                .value_in (s_tdata),
                .wr_value (value_reg),
                .tail_in  (tail_reg),
                .hit      (hit_vec[gi]),
                .tail_out (tail_vec[gi])
            );
        end
    endgenerate

    // Only the last valid cell drives tail_out, so an OR picks it.
    always_comb
    begin
        tail_next = tail_reg;
        if (accept)
        begin
            tail_next = '0;
            for (int i = 0; i < SET_DEPTH; i++)
            begin
                tail_next = tail_next | tail_vec[i];
            end
        end
    end

    // Entries are distinct below count, so hit_vec is one-hot or zero.
    always_comb
    begin
        slot_enc = '0;
        for (int i = 0; i < SET_DEPTH; i++)
        begin
            if (hit_vec[i])
            begin
                slot_enc = slot_enc | IW'(i);
            end
        end
    end
    assign found_any = |hit_vec;

    assign eff_limit = (LW'(cap_reg) > LW'(SET_DEPTH)) ? LW'(SET_DEPTH) : LW'(cap_reg);
    assign at_limit  = LW'(count_reg) >= eff_limit;

    // ---- execute step ----
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        ctl.sample   = accept;
        ctl.add_en   = 1'b0;
        ctl.rem_en   = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next.found   = found_any;
                res_next.slot    = SLOT_W'(slot_enc);
                res_next.outcome = OUT_DONE;
                unique case (cmd_reg)
                    CMD_QUERY:
                    begin
                    end
                    CMD_ADD:
                    begin
                        if (found_any)
                        begin
                            res_next.outcome = OUT_DUP;
                        end
                        else if (at_limit)
                        begin
                            res_next.outcome = OUT_FULL;
                        end
                        else
                        begin
                            ctl.add_en = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!found_any)
                        begin
                            res_next.outcome = OUT_ABSENT;
                        end
                        else
                        begin
                            ctl.rem_en = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_CLEAR:
                    begin
                        res_next.found = 1'b0;
                        res_next.slot  = '0;
                        count_next     = '0;
                    end
                    default:
                    begin
                    end
                endcase
                res_next.element_count = COUNT_W'(count_next);
                res_next.is_full       = LW'(count_next) >= eff_limit;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CFG_W'(64);
            count_reg   <= '0;
            cmd_reg     <= CMD_QUERY;
            value_reg   <= '0;
            tail_reg    <= '0;
            res_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tail_reg    <= tail_next;
            res_reg     <= res_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cmd_reg   <= cmd_t'(s_tuser);
                value_reg <= s_tdata;
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sist_pkg::*;

    localparam int SET_DEPTH    = 64;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 175;
    localparam int POOL_MAX     = 96;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_AFTER   = 500;    // results taken before the long stall
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    // One row of the directed table: either a limit write or an item.
    // Rows with 'known' set carry a hand-typed result; the rest use the predictor.
    typedef struct {
        bit         is_cfg;
        logic [6:0] limit;
        cmd_t       op;
        logic [31:0] val;
        bit         known;
        result_t    want;
    } step_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;      // value
    logic [1:0]  s_tuser   = '0;      // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // found, slot, outcome, element_count, is_full

    // Shadow copy of the set, kept in step with accepted input beats.
    logic [31:0] held [SET_DEPTH];
    int unsigned held_count;
    int unsigned cap_limit;

    result_t     pending_results [$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    bit          tx_quiet   = 1'b0;
    bit          rx_quiet   = 1'b0;

    step_row_t   steps [$];

    small_integer_set_table #(
        .SET_DEPTH (SET_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the shadow set and returns the result it must give.
    // Lookup happens before the update, so found/slot on add and remove
    // describe the table as it was. Clear does no lookup at all.
    function automatic result_t apply_set_cmd(cmd_t op, logic [31:0] v);
        result_t     r;
        int unsigned lim;
        int unsigned where;
        bit          hit;
        lim   = (cap_limit > SET_DEPTH) ? SET_DEPTH : cap_limit;
        hit   = 1'b0;
        where = 0;
        r     = '0;
        r.outcome = OUT_DONE;
        if (op != CMD_CLEAR)
        begin
            for (int unsigned i = 0; i < held_count; i++)
            begin
                if (!hit && held[i] == v)
                begin
                    hit   = 1'b1;
                    where = i;
                end
            end
        end
        case (op)
            CMD_ADD:
            begin
                // duplicate wins over full
                if (hit)
                    r.outcome = OUT_DUP;
                else if (held_count >= lim)
                    r.outcome = OUT_FULL;
                else
                begin
                    held[held_count] = v;
                    held_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (!hit)
                    r.outcome = OUT_ABSENT;
                else
                begin
                    // tail entry fills the hole
                    held_count--;
                    held[where] = held[held_count];
                end
            end
            CMD_CLEAR:
                held_count = 0;
            default:
                ;
        endcase
        r.found         = hit;
        r.slot          = where[SLOT_W-1:0];
        r.element_count = held_count[COUNT_W-1:0];
        r.is_full       = (held_count >= lim);
        return r;
    endfunction

    function automatic step_row_t limit_row(logic [6:0] v);
        step_row_t row;
        row        = '{default: '0, op: CMD_QUERY, want: '0};
        row.is_cfg = 1'b1;
        row.limit  = v;
        return row;
    endfunction

    function automatic step_row_t item_row(cmd_t op, logic [31:0] v);
        step_row_t row;
        row     = '{default: '0, op: CMD_QUERY, want: '0};
        row.op  = op;
        row.val = v;
        return row;
    endfunction

    function automatic step_row_t known_row(cmd_t op, logic [31:0] v, int f,
                                            int s, outcome_t o,
                                            int c, int full);
        step_row_t row;
        row                    = item_row(op, v);
        row.known              = 1'b1;
        row.want.found         = f[0];
        row.want.slot          = s[SLOT_W-1:0];
        row.want.outcome       = o;
        row.want.element_count = c[COUNT_W-1:0];
        row.want.is_full       = full[0];
        return row;
    endfunction

    // Limit writes only while nothing is in flight; the predictor follows
    // at the same edge.
    task automatic write_limit(logic [6:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_limit = v;
    endtask

    // Drop valid, then wait for every outstanding result plus a short pause.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offers one input beat after a random gap; valid stays high across
    // back-to-back beats. Expectation is queued at the accept edge.
    task automatic send_item(cmd_t op, logic [31:0] v, bit known, result_t want);
        int      gap;
        result_t pred;
        if ($urandom_range(0, 29) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        pred = apply_set_cmd(op, v);
        pending_results.push_back(known ? want : pred);
    endtask

    initial
    begin : stimulus
        int unsigned phase_limits [PHASES];
        logic [31:0] pool [POOL_MAX];
        int unsigned pool_n;
        int unsigned add_pm;
        int unsigned roll;
        cmd_t        op;
        logic [31:0] v;

        phase_limits = '{127, 64, 1, 5, 0, 17, 64, 2, 100, 40};
        held_count = 0;
        cap_limit  = SET_DEPTH;

        // Directed table. Starts from reset state with limit 64.
        steps.push_back(known_row(CMD_QUERY,  32'h0000_0000, 0, 0, OUT_DONE,   0, 0));
        steps.push_back(known_row(CMD_REMOVE, 32'h0000_0005, 0, 0, OUT_ABSENT, 0, 0));
        steps.push_back(known_row(CMD_ADD,    32'h8000_0000, 0, 0, OUT_DONE,   1, 0));
        steps.push_back(known_row(CMD_ADD,    32'h7fff_ffff, 0, 0, OUT_DONE,   2, 0));
        steps.push_back(item_row(CMD_ADD,     32'h0000_0000));
        steps.push_back(item_row(CMD_ADD,     32'hffff_ffff));
        steps.push_back(known_row(CMD_ADD,    32'h8000_0000, 1, 0, OUT_DUP,    4, 0));
        steps.push_back(item_row(CMD_QUERY,   32'h7fff_ffff));
        // remove from slot 0: tail entry moves down into it
        steps.push_back(item_row(CMD_REMOVE,  32'h8000_0000));
        steps.push_back(item_row(CMD_QUERY,   32'hffff_ffff));
        steps.push_back(known_row(CMD_CLEAR,  32'hdead_beef, 0, 0, OUT_DONE,   0, 0));
        steps.push_back(known_row(CMD_QUERY,  32'hffff_ffff, 0, 0, OUT_DONE,   0, 0));
        // small limit: fill, then full and duplicate-over-full
        steps.push_back(limit_row(7'd2));
        steps.push_back(item_row(CMD_ADD,     32'd10));
        steps.push_back(item_row(CMD_ADD,     32'd20));
        steps.push_back(known_row(CMD_ADD,    32'd30, 0, 0, OUT_FULL, 2, 1));
        steps.push_back(known_row(CMD_ADD,    32'd10, 1, 0, OUT_DUP,  2, 1));
        // limit dropped below count: entries stay, set reads full
        steps.push_back(limit_row(7'd1));
        steps.push_back(known_row(CMD_ADD,    32'd40, 0, 0, OUT_FULL, 2, 1));
        steps.push_back(item_row(CMD_QUERY,   32'd20));
        // zero limit refuses every add and always reports full
        steps.push_back(limit_row(7'd0));
        steps.push_back(item_row(CMD_REMOVE,  32'd20));
        steps.push_back(known_row(CMD_ADD,    32'd50, 0, 0, OUT_FULL, 1, 1));
        steps.push_back(known_row(CMD_CLEAR,  32'd0,  0, 0, OUT_DONE, 0, 1));
        steps.push_back(known_row(CMD_ADD,    32'd7,  0, 0, OUT_FULL, 0, 1));
        // limit above depth saturates
        steps.push_back(limit_row(7'd127));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
            begin
                wait_idle();
                write_limit(steps[i].limit);
            end
            else
                send_item(steps[i].op, steps[i].val, steps[i].known, steps[i].want);
        end

        // Random part: one limit per phase, mostly well-formed traffic on a
        // small value pool so adds, hits and removes keep meeting each other.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_limit(phase_limits[p][6:0]);
            pool_n = (phase_limits[p] < 16) ? 12 : POOL_MAX;
            pool[0] = 32'h0000_0000;
            pool[1] = 32'hffff_ffff;
            pool[2] = 32'h8000_0000;
            pool[3] = 32'h7fff_ffff;
            for (int k = 4; k < POOL_MAX; k++)
                pool[k] = $urandom;
            // big limits get add-heavy traffic so the set actually fills
            add_pm = (phase_limits[p] >= 33) ? 650 : 450;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 999);
                if (roll < 8)
                    op = CMD_CLEAR;
                else if (roll < 8 + add_pm)
                    op = CMD_ADD;
                else if (roll < 8 + add_pm + (992 - add_pm) / 2)
                    op = CMD_REMOVE;
                else
                    op = CMD_QUERY;
                if (held_count > 0 && $urandom_range(0, 2) == 0)
                    v = held[$urandom_range(0, held_count - 1)];
                else if ($urandom_range(0, 6) == 0)
                    v = $urandom;
                else
                    v = pool[$urandom_range(0, pool_n - 1)];
                send_item(op, v, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random stalls per beat, plus one long hold-off once
    // traffic is flowing so the block backs up into its input.
    initial
    begin : result_sink
        int          gap;
        int unsigned rx_beats;
        bit          held_off;
        rx_beats = 0;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_quiet = !rx_quiet;
            gap = rx_quiet ? 0 : $urandom_range(0, 6);
            if (!held_off && rx_beats >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            rx_beats++;
        end
    end

    // Compare every output beat against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing pending: %h", $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.slot !== want.slot ||
                    got.outcome !== want.outcome ||
                    got.element_count !== want.element_count ||
                    got.is_full !== want.is_full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch found/slot/outcome/count/full ",
                                  "exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d"},
                                 $realtime, want.found, want.slot, want.outcome,
                                 want.element_count, want.is_full, got.found, got.slot,
                                 got.outcome, got.element_count, got.is_full);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
